// File: sv/rcmd_pkg.sv
// Shared types and constants for the repetition code majority decoder.
package rcmd_pkg;

    // Key byte and code word widths
    localparam int KEY_W      = 8;
    localparam int CNT_W      = $clog2(KEY_W);
    localparam int ONES_W     = $clog2(KEY_W + 1);
    localparam int MINOR_W    = 3;
    localparam int OUT_ERR_W  = 14;
    localparam int ERR_W_DEF  = 14;

    // Decode thresholds and packer limits
    localparam logic [ONES_W-1:0] MAJORITY_MIN = ONES_W'(5);
    localparam logic [ONES_W-1:0] WORD_BITS    = ONES_W'(KEY_W);
    localparam logic [CNT_W-1:0]  CNT_FULL     = CNT_W'(KEY_W - 1);
    localparam logic [OUT_ERR_W-1:0] OUT_ERR_MAX = {OUT_ERR_W{1'b1}};

    // Result of decoding one code word
    typedef struct packed {
        logic               dec_bit;
        logic [MINOR_W-1:0] minority;
    } t_decode;

endpackage

// File: sv/rcmd_word_decode.sv
// Code word decode: unmask, popcount, majority bit and minority count.
module rcmd_word_decode
    import rcmd_pkg::*;
(
    input  logic [KEY_W-1:0] i_code_byte,
    input  logic [KEY_W-1:0] i_helper_byte,
    output t_decode          o_decode
);

    logic [KEY_W-1:0]  word;
    logic [ONES_W-1:0] ones;
    logic [ONES_W-1:0] minority_full;

    // Unmask the response and count set bits
    always_comb begin
        word = i_code_byte ^ i_helper_byte;
        ones = '0;
        for (int i = 0; i < KEY_W; i++) begin
            ones = ones + ONES_W'(word[i]);
        end
    end

    // Pick the majority bit and count the bits that disagree with it
    always_comb begin
        o_decode.dec_bit = (ones >= MAJORITY_MIN);
        if (o_decode.dec_bit) begin
            minority_full = WORD_BITS - ones;
        end else begin
            minority_full = ones;
        end
        o_decode.minority = minority_full[MINOR_W-1:0];
    end

endmodule

// File: sv/repetition_code_majority_decoder.sv
// Top level of the repetition code majority decoder.
//
// Input channel: i_in_valid / o_in_ready carry one masked response byte, its
// helper byte and a last flag per transaction. Each transaction decodes one
// key bit by majority over the XOR of the two bytes.
// Output channel: o_out_valid / i_out_ready carry one key byte, the running
// corrected-error total and a last flag. A key byte leaves after every eighth
// code word, and on a code word flagged last any partial byte leaves
// left-aligned with zero low bits.
// A transaction accepted into the input register is decoded into the output
// register once the output slot is free.
// Throughput: one code word per cycle while the receiver does not stall; the
// single pass of popcount, packer shift and saturating error add between the
// input and output registers sets that figure.
// The error total saturates at all ones of ERR_WIDTH bits, is shown clamped
// to 14 bits, and is cleared only by reset, not by the last flag.
// Reset (i_rst_n low, synchronous) empties both registers and clears the
// packer, the bit count and the error total.
// When the receiver stalls, the result holds in the output register and one
// more transaction waits in the input register; o_in_ready then drops.
module repetition_code_majority_decoder
    import rcmd_pkg::*;
#(
    parameter int ERR_WIDTH = ERR_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [KEY_W-1:0]     i_code_byte,
    input  logic [KEY_W-1:0]     i_helper_byte,
    input  logic                 i_in_last,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [KEY_W-1:0]     o_key_byte,
    output logic [OUT_ERR_W-1:0] o_error_total,
    output logic                 o_out_last
);

    // Input register
    logic             r_s1_valid;
    logic [KEY_W-1:0] r_s1_code;
    logic [KEY_W-1:0] r_s1_helper;
    logic             r_s1_last;

    // Decoder state
    logic [KEY_W-2:0]     r_packer, n_packer;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [ERR_WIDTH-1:0] r_acc, n_acc;

    // Output register
    logic                 r_out_valid;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [OUT_ERR_W-1:0] r_err, n_err;
    logic                 r_out_last;

    t_decode            dec;
    logic               out_free;
    logic               s1_move;
    logic               emit;
    logic [KEY_W-1:0]   packed_bits;
    logic [ERR_WIDTH:0] acc_sum;
    logic [CNT_W-1:0]   shift;

    rcmd_word_decode u_decode (
        .i_code_byte   (r_s1_code),
        .i_helper_byte (r_s1_helper),
        .o_decode      (dec)
    );

    // Handshake: advance the input stage whenever the output slot frees
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || s1_move;

    // Saturating error add
    always_comb begin
        acc_sum = {1'b0, r_acc} + (ERR_WIDTH + 1)'(dec.minority);
        if (acc_sum[ERR_WIDTH]) begin
            n_acc = {ERR_WIDTH{1'b1}};
        end else begin
            n_acc = acc_sum[ERR_WIDTH-1:0];
        end
    end

    // Clamp or zero-extend the running total to the output field width
    generate
        if (ERR_WIDTH > OUT_ERR_W) begin : g_err_clamp
            always_comb begin
                if (n_acc > ERR_WIDTH'(OUT_ERR_MAX)) begin
                    n_err = OUT_ERR_MAX;
                end else begin
                    n_err = n_acc[OUT_ERR_W-1:0];
                end
            end
        end else if (ERR_WIDTH == OUT_ERR_W) begin : g_err_same
            assign n_err = n_acc;
        end else begin : g_err_extend
            assign n_err = {{(OUT_ERR_W - ERR_WIDTH){1'b0}}, n_acc};
        end
    endgenerate

    // Pack the new bit, left-align the byte and decide whether to emit
    always_comb begin
        packed_bits = {r_packer, dec.dec_bit};
        shift       = CNT_FULL - r_count;
        n_key       = packed_bits << shift;
        emit        = (r_count == CNT_FULL) || r_s1_last;
        if (emit) begin
            n_packer = '0;
            n_count  = '0;
        end else begin
            n_packer = packed_bits[KEY_W-2:0];
            n_count  = r_count + CNT_W'(1);
        end
    end

    // Hold control state and valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_packer    <= '0;
            r_count     <= '0;
            r_acc       <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_move) begin
                r_out_valid <= emit;
                r_packer    <= n_packer;
                r_count     <= n_count;
                r_acc       <= n_acc;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_code   <= i_code_byte;
            r_s1_helper <= i_helper_byte;
            r_s1_last   <= i_in_last;
        end
        if (s1_move && emit) begin
            r_key      <= n_key;
            r_err      <= n_err;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_byte    = r_key;
    assign o_error_total = r_err;
    assign o_out_last    = r_out_last;

    // A last code word leaves the packer empty
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_last) |=> (r_count == '0 && r_packer == '0))
        else $error("packer not cleared after last code word");

    // The error total never decreases outside reset
    a_err_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_acc >= $past(r_acc)))
        else $error("error total decreased");

    // No result without a full byte or a last flag
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_count != CNT_FULL && !r_s1_last) |=> !o_out_valid)
        else $error("result emitted mid-byte");

endmodule

// File: bench/key_byte_checker.sv
// Checker that predicts decoded key bytes and compares them with the decoder output.
`timescale 1ns / 1ps

module key_byte_checker
    import rcmd_pkg::*;
#(
    parameter int ERR_WIDTH = ERR_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [KEY_W-1:0]     i_code_byte,
    input  logic [KEY_W-1:0]     i_helper_byte,
    input  logic                 i_in_last,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [KEY_W-1:0]     i_key_byte,
    input  logic [OUT_ERR_W-1:0] i_error_total,
    input  logic                 i_out_last,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [OUT_ERR_W-1:0] err;
        logic                 last;
    } t_key_result;

    localparam logic [ERR_WIDTH-1:0] ERR_SAT = {ERR_WIDTH{1'b1}};

    // Predicted key bytes not yet seen on the output channel
    t_key_result      exp_key_bytes[$];

    // Own copy of the decoder state
    logic [KEY_W-2:0]     held_bits;
    logic [CNT_W-1:0]     held_count;
    logic [ERR_WIDTH-1:0] err_acc;
    int                   mismatches = 0;

    // Decode one code word, update the state and queue a key byte when one leaves
    task automatic predict_word(input logic [KEY_W-1:0] code, input logic [KEY_W-1:0] helper,
                                input logic last);
        logic [KEY_W-1:0]   word;
        int                 ones;
        logic               dec;
        int                 minority;
        logic [ERR_WIDTH:0] sum;
        logic [KEY_W-1:0]   shifted;
        t_key_result        res;
        word     = code ^ helper;
        ones     = $countones(word);
        dec      = (ones >= 5);
        minority = dec ? (KEY_W - ones) : ones;
        sum      = {1'b0, err_acc} + (ERR_WIDTH + 1)'(minority);
        if (sum > {1'b0, ERR_SAT}) begin
            sum = {1'b0, ERR_SAT};
        end
        err_acc = sum[ERR_WIDTH-1:0];
        shifted = {held_bits, dec};
        if (held_count == CNT_FULL || last) begin
            res.key  = shifted << (CNT_FULL - held_count);
            if (64'(err_acc) > 64'(OUT_ERR_MAX)) begin
                res.err = OUT_ERR_MAX;
            end else begin
                res.err = OUT_ERR_W'(err_acc);
            end
            res.last = last;
            exp_key_bytes.push_back(res);
            held_bits  = '0;
            held_count = '0;
        end else begin
            held_bits  = shifted[KEY_W-2:0];
            held_count = held_count + 1'b1;
        end
    endtask

    // Watch both channels at every edge
    always @(posedge i_clk) begin
        t_key_result want;
        if (!i_rst_n) begin
            held_bits  = '0;
            held_count = '0;
            err_acc    = '0;
            exp_key_bytes.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_word(i_code_byte, i_helper_byte, i_in_last);
            end
            if (i_out_valid && i_out_ready) begin
                if (exp_key_bytes.size() == 0) begin
                    $display("%0t: extra key byte: expected none, actual %h err %0d last %b",
                             $time, i_key_byte, i_error_total, i_out_last);
                    mismatches++;
                end else begin
                    want = exp_key_bytes.pop_front();
                    if (i_key_byte !== want.key) begin
                        $display("%0t: key_byte mismatch: expected %h, actual %h",
                                 $time, want.key, i_key_byte);
                        mismatches++;
                    end
                    if (i_error_total !== want.err) begin
                        $display("%0t: error_total mismatch: expected %0d, actual %0d",
                                 $time, want.err, i_error_total);
                        mismatches++;
                    end
                    if (i_out_last !== want.last) begin
                        $display("%0t: out_last mismatch: expected %b, actual %b",
                                 $time, want.last, i_out_last);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= exp_key_bytes.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: bench/repetition_code_majority_decoder_test.sv
// Stimulus and verdict for the repetition code majority decoder.
`timescale 1ns / 1ps

module repetition_code_majority_decoder_test
    import rcmd_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic [KEY_W-1:0]     i_code_byte   = '0;
    logic [KEY_W-1:0]     i_helper_byte = '0;
    logic                 i_in_last     = 1'b0;
    logic                 i_out_ready   = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [KEY_W-1:0]     o_key_byte;
    logic [OUT_ERR_W-1:0] o_error_total;
    logic                 o_out_last;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int words_sent  = 0;
    int cycle_count = 0;
    int fail_count;
    int pending;

    repetition_code_majority_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_code_byte   (i_code_byte),
        .i_helper_byte (i_helper_byte),
        .i_in_last     (i_in_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_key_byte    (o_key_byte),
        .o_error_total (o_error_total),
        .o_out_last    (o_out_last)
    );

    key_byte_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_code_byte   (i_code_byte),
        .i_helper_byte (i_helper_byte),
        .i_in_last     (i_in_last),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_key_byte    (o_key_byte),
        .i_error_total (o_error_total),
        .i_out_last    (o_out_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #1 i_clk = ~i_clk;

    // Stall the receiver at the rate of the current phase
    always @(posedge i_clk) begin
        i_out_ready <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Code word with a given number of set bits at random places
    function automatic logic [KEY_W-1:0] ones_word(input int ones);
        logic [KEY_W-1:0] w;
        logic [CNT_W-1:0] pos;
        w = '0;
        while ($countones(w) < ones) begin
            pos    = CNT_W'($urandom_range(KEY_W-1));
            w[pos] = 1'b1;
        end
        return w;
    endfunction

    // Drive one transaction, idling first at the phase rate, and hold it until accepted
    task automatic send_word(input logic [KEY_W-1:0] code, input logic [KEY_W-1:0] helper,
                             input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_code_byte   <= code;
        i_helper_byte <= helper;
        i_in_last     <= last;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    // Send a key of nbits code words, last flag on the final one; ones < 0 means any popcount
    task automatic send_key(input int nbits, input int ones);
        logic [KEY_W-1:0] helper;
        int               n;
        for (int i = 0; i < nbits; i++) begin
            n      = (ones < 0) ? $urandom_range(KEY_W) : ones;
            helper = KEY_W'($urandom);
            send_word(ones_word(n) ^ helper, helper, i == nbits - 1);
        end
    endtask

    function automatic int key_length();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return 1;
        end else if (r < 25) begin
            return KEY_W * $urandom_range(1, 4);
        end
        return $urandom_range(2, 40);
    endfunction

    // Mostly whole keys, some loose words with a random last flag
    task automatic run_phase(input int idle, input int stall, input int count, input int ones);
        int target;
        logic [KEY_W-1:0] helper;
        idle_pct  = idle;
        stall_pct = stall;
        target    = words_sent + count;
        while (words_sent < target) begin
            if ($urandom_range(99) < 85) begin
                send_key(key_length(), ones);
            end else begin
                helper = KEY_W'($urandom);
                send_word(KEY_W'($urandom), helper, $urandom_range(99) < 30);
            end
        end
    endtask

    initial begin
        logic [KEY_W-1:0] helper;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Popcount extremes and the 4/5 majority boundary, one full byte
        send_word(8'h00, 8'h00, 1'b0);
        send_word(8'hFF, 8'h00, 1'b0);
        send_word(8'hFF, 8'hFF, 1'b0);
        send_word(8'h00, 8'hFF, 1'b0);
        send_word(8'h0F, 8'h00, 1'b0);
        send_word(8'h1F, 8'h00, 1'b0);
        send_word(8'hF0, 8'h01, 1'b0);
        send_word(8'h87, 8'h00, 1'b0);

        // One-bit key: partial byte with a single held bit
        send_word(8'hFE, 8'h01, 1'b1);

        // Seven-bit key: partial byte with one padding bit
        for (int i = 0; i < 7; i++) begin
            helper = KEY_W'($urandom);
            send_word(ones_word((i % 2 == 0) ? 5 : 4) ^ helper, helper, i == 6);
        end

        // Eight-bit key: full byte carrying the last flag
        for (int i = 0; i < KEY_W; i++) begin
            helper = KEY_W'($urandom);
            send_word(ones_word(i) ^ helper, helper, i == KEY_W - 1);
        end

        // Random content under each idling mix
        run_phase(0, 0, 190, -1);
        run_phase(65, 0, 190, -1);
        run_phase(0, 65, 190, -1);
        run_phase(30, 30, 190, -1);

        // Heavy-error words push the error total up at the fastest pace
        run_phase(0, 0, 45, 4);
        run_phase(65, 0, 45, 4);
        run_phase(0, 65, 45, 4);
        run_phase(30, 30, 45, 4);

        // Drain the output channel
        stall_pct  = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
sv/rcmd_pkg.sv
sv/rcmd_word_decode.sv
sv/repetition_code_majority_decoder.sv
bench/key_byte_checker.sv
bench/repetition_code_majority_decoder_test.sv
